[design/swif_pkg.sv]
// shared types and constants for the seed window interval finder
package swif_pkg;

   localparam int MAX_SEEDS_DEFAULT  = 64;
   localparam int MAX_SEEDS_LIMIT    = 64;
   localparam int JOB_COUNT_W        = $clog2(MAX_SEEDS_LIMIT + 1);
   localparam int REF_W              = 16;
   localparam int POS_W              = 32;
   localparam int IDX_W              = 6;
   localparam logic [POS_W-1:0] MAX_INTERVAL_RESET = 32'd1024;

   typedef struct packed {
      logic [REF_W-1:0] ref_index;
      logic [POS_W-1:0] seed_begin;
      logic [POS_W-1:0] seed_end;
      logic             last_seed;
   } req_payload_type;

   typedef struct packed {
      logic [REF_W-1:0] interval_ref;
      logic [IDX_W-1:0] interval_start;
      logic [IDX_W-1:0] interval_end;
      logic             last_interval;
   } rsp_payload_type;

   typedef struct packed {
      logic [REF_W-1:0]       ref_index;
      logic [JOB_COUNT_W-1:0] seed_count;
      logic                   bank;
   } job_type;

endpackage

[design/swif_ram.sv]
// generic single write port ram with registered read
module swif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/swif_job_fifo.sv]
// two entry queue of seed set jobs between front and back
module swif_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              push_ready,
   input  swif_pkg::job_type push_data,
   input  logic              pop,
   output logic              pop_valid,
   output swif_pkg::job_type pop_data
);
   import swif_pkg::*;

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/swif_front.sv]
// seed intake: stores seeds into the free bank and posts a job per set
module swif_front #(
   parameter int MAX_SEEDS = swif_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swif_pkg::req_payload_type           req_payload,
   input  logic                                job_ready,
   output logic                                job_push,
   output swif_pkg::job_type                   job,
   output logic                                seed_wr_en,
   output logic [$clog2(MAX_SEEDS):0]          seed_wr_addr,
   output logic [swif_pkg::POS_W-1:0]          seed_wr_begin,
   output logic [swif_pkg::POS_W-1:0]          seed_wr_end
);
   import swif_pkg::*;

   localparam int IW = $clog2(MAX_SEEDS);
   localparam int CW = $clog2(MAX_SEEDS + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff, bank_in;
   logic          accept;
   logic          room;
   logic [CW-1:0] count_next;

   assign req_ready  = job_ready;
   assign accept     = req_valid && req_ready;
   assign room       = (count_ff < CW'(MAX_SEEDS));
   assign seed_wr_en = accept && room;
   assign count_next = (accept && room) ? count_ff + CW'(1) : count_ff;

   assign seed_wr_addr  = {bank_ff, count_ff[IW-1:0]};
   assign seed_wr_begin = req_payload.seed_begin;
   assign seed_wr_end   = req_payload.seed_end;

   assign job_push       = accept && req_payload.last_seed;
   assign job.ref_index  = req_payload.ref_index;
   assign job.seed_count = JOB_COUNT_W'(count_next);
   assign job.bank       = bank_ff;

   always_comb begin
      count_in = count_next;
      bank_in  = bank_ff;
      if (job_push) begin
         count_in = '0;
         bank_in  = ~bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

[design/swif_back.sv]
// two pointer window walk over one stored seed set, one pointer step per cycle unless the output stalls
module swif_back #(
   parameter int MAX_SEEDS = swif_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [swif_pkg::POS_W-1:0]      max_interval_size,
   input  logic                            job_valid,
   input  swif_pkg::job_type               job,
   output logic                            job_pop,
   output logic [$clog2(MAX_SEEDS):0]      begin_rd_addr,
   output logic [$clog2(MAX_SEEDS):0]      end_rd_addr,
   input  logic [swif_pkg::POS_W-1:0]      begin_rd_data,
   input  logic [swif_pkg::POS_W-1:0]      end_rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output swif_pkg::rsp_payload_type       rsp_payload
);
   import swif_pkg::*;

   localparam int IW = $clog2(MAX_SEEDS);
   localparam int CW = $clog2(MAX_SEEDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   start_ff, start_in;
   logic [CW-1:0]   cur_ff, cur_in;
   logic [CW-1:0]   prev_ff, prev_in;
   logic            pend_valid_ff, pend_valid_in;
   rsp_payload_type pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [CW-1:0]   n;
   logic [CW-1:0]   cur_plus1;
   logic [CW-1:0]   start_plus1;
   logic [CW-1:0]   cur_in_plus1;
   logic [POS_W:0]  limit;
   logic            can_adv;
   logic            emit_now;
   logic            out_free;
   logic            stall;
   logic            step;
   logic            done;

   assign n           = job.seed_count[CW-1:0];
   assign cur_plus1   = cur_ff + CW'(1);
   assign start_plus1 = start_ff + CW'(1);
   assign limit       = {1'b0, begin_rd_data} + {1'b0, max_interval_size};
   assign can_adv     = (cur_plus1 < n) && (limit > {1'b0, end_rd_data});
   assign emit_now    = (state_ff == ST_WALK) && !can_adv && (cur_ff != prev_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign stall       = emit_now && pend_valid_ff && !out_free;
   assign step        = (state_ff == ST_WALK) && !stall;
   assign done        = step && !can_adv &&
                        ((emit_now && (cur_ff == n - CW'(1))) || (start_plus1 == n));

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      job_pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            start_in = '0;
            cur_in   = CW'(1);
            prev_in  = '0;
            if (job_valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (step) begin
               if (can_adv) begin
                  cur_in = cur_plus1;
               end else begin
                  start_in = start_plus1;
                  if (emit_now) begin
                     pend_in.interval_ref   = job.ref_index;
                     pend_in.interval_start = IDX_W'(start_ff);
                     pend_in.interval_end   = IDX_W'(cur_ff);
                     pend_in.last_interval  = 1'b0;
                     pend_valid_in          = 1'b1;
                     prev_in                = cur_ff;
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                     end
                  end
               end
               if (done) begin
                  state_in = ST_FLUSH;
                  job_pop  = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = pend_ff;
               rsp_in.last_interval = 1'b1;
               pend_valid_in        = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cur_in_plus1  = cur_in + CW'(1);
   assign begin_rd_addr = {job.bank, start_in[IW-1:0]};
   assign end_rd_addr   = {job.bank, cur_in_plus1[IW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_ff      <= '0;
         cur_ff        <= CW'(1);
         prev_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_ff      <= start_in;
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_walk_has_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> job_valid)
      else $error("walk running without a queued job");

   a_walk_start_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (start_ff < n))
      else $error("start pointer beyond seed set");

   a_flush_has_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_valid_ff)
      else $error("set closed without any interval");

   a_pop_ends_walk: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == ST_FLUSH))
      else $error("job released while walk continues");

endmodule

[design/seed_window_interval_finder_unit.sv]
// top level of the seed window interval finder
// seeds are taken one per cycle while the job queue has room; two seed banks let a set load
// while the previous set is walked, one pointer step per cycle unless the output stalls;
// each interval is held until the next is found or the set is flushed; reset is synchronous,
// clears queue, pointers, counters and output valid, sets max_interval_size to 1024, keeps
// seed rams
module seed_window_interval_finder_unit #(
   parameter int MAX_SEEDS = swif_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  swif_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output swif_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [swif_pkg::POS_W-1:0]    csr_wr_data
);
   import swif_pkg::*;

   localparam int AW = $clog2(MAX_SEEDS) + 1;

   logic [POS_W-1:0] max_interval_size_ff, max_interval_size_in;

   logic             job_push;
   logic             job_ready;
   job_type          job_in_data;
   logic             job_pop;
   logic             job_valid;
   job_type          job_head;

   logic             seed_wr_en;
   logic [AW-1:0]    seed_wr_addr;
   logic [POS_W-1:0] seed_wr_begin;
   logic [POS_W-1:0] seed_wr_end;
   logic [AW-1:0]    begin_rd_addr;
   logic [AW-1:0]    end_rd_addr;
   logic [POS_W-1:0] begin_rd_data;
   logic [POS_W-1:0] end_rd_data;

   assign max_interval_size_in = csr_wr_en ? csr_wr_data : max_interval_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_interval_size_ff <= MAX_INTERVAL_RESET;
      end else begin
         max_interval_size_ff <= max_interval_size_in;
      end
   end

   swif_front #(.MAX_SEEDS(MAX_SEEDS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .job_ready     (job_ready),
      .job_push      (job_push),
      .job           (job_in_data),
      .seed_wr_en    (seed_wr_en),
      .seed_wr_addr  (seed_wr_addr),
      .seed_wr_begin (seed_wr_begin),
      .seed_wr_end   (seed_wr_end)
   );

   swif_job_fifo u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_ready (job_ready),
      .push_data  (job_in_data),
      .pop        (job_pop),
      .pop_valid  (job_valid),
      .pop_data   (job_head)
   );

   swif_ram #(.WIDTH(POS_W), .DEPTH(2 ** AW)) u_begin_ram (
      .clock   (clock),
      .wr_en   (seed_wr_en),
      .wr_addr (seed_wr_addr),
      .wr_data (seed_wr_begin),
      .rd_addr (begin_rd_addr),
      .rd_data (begin_rd_data)
   );

   swif_ram #(.WIDTH(POS_W), .DEPTH(2 ** AW)) u_end_ram (
      .clock   (clock),
      .wr_en   (seed_wr_en),
      .wr_addr (seed_wr_addr),
      .wr_data (seed_wr_end),
      .rd_addr (end_rd_addr),
      .rd_data (end_rd_data)
   );

   swif_back #(.MAX_SEEDS(MAX_SEEDS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .max_interval_size (max_interval_size_ff),
      .job_valid         (job_valid),
      .job               (job_head),
      .job_pop           (job_pop),
      .begin_rd_addr     (begin_rd_addr),
      .end_rd_addr       (end_rd_addr),
      .begin_rd_data     (begin_rd_data),
      .end_rd_data       (end_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload)
   );

endmodule
